### design/kfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfp_pkg
// Shared types, codes and header helpers for the KWP2000 frame packer.
// ----------------------------------------------------------------------------
package kfp_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [2:0] mode_t;
  typedef logic [1:0] kind_t;
  typedef logic [1:0] cfg_idx_t;

  // Header formats
  localparam mode_t MODE_8X   = 3'd0;
  localparam mode_t MODE_CX   = 3'd1;
  localparam mode_t MODE_80   = 3'd2;
  localparam mode_t MODE_00   = 3'd3;
  localparam mode_t MODE_LEN  = 3'd4;

  // Result byte kinds
  localparam kind_t KIND_HEADER   = 2'd0;
  localparam kind_t KIND_PAYLOAD  = 2'd1;
  localparam kind_t KIND_CHECKSUM = 2'd2;

  // Configuration register indexes
  localparam cfg_idx_t CFG_FRAME_MODE = 2'd0;
  localparam cfg_idx_t CFG_TARGET     = 2'd1;
  localparam cfg_idx_t CFG_SOURCE     = 2'd2;

  localparam byte_t FMT_8X = 8'h80;
  localparam byte_t FMT_CX = 8'hC0;
  localparam byte_t FMT_00 = 8'h00;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_START,
    ST_HDR,
    ST_PAY,
    ST_SUM
  } seq_state_t;

  // One result byte on its way to the output register
  typedef struct packed {
    logic  valid;
    byte_t data;
    kind_t kind;
    logic  eof;
  } emit_t;

  // Number of header bytes for a mode
  function automatic logic [2:0] hdr_count(input mode_t mode);
    logic [2:0] cnt;
    case (mode)
      MODE_8X: cnt = 3'd3;
      MODE_CX: cnt = 3'd3;
      MODE_80: cnt = 3'd4;
      MODE_00: cnt = 3'd2;
      default: cnt = 3'd1;
    endcase
    return cnt;
  endfunction

  // Header byte at position idx for a mode
  function automatic byte_t hdr_byte(input mode_t mode, input logic [1:0] idx,
                                     input byte_t len, input byte_t tar,
                                     input byte_t src);
    byte_t b;
    b = len;
    case (mode)
      MODE_8X, MODE_CX: begin
        case (idx)
          2'd0:    b = ((mode == MODE_8X) ? FMT_8X : FMT_CX) | len;
          2'd1:    b = tar;
          default: b = src;
        endcase
      end
      MODE_80: begin
        case (idx)
          2'd0:    b = FMT_8X;
          2'd1:    b = tar;
          2'd2:    b = src;
          default: b = len;
        endcase
      end
      MODE_00: begin
        b = (idx == 2'd0) ? FMT_00 : len;
      end
      default: b = len;
    endcase
    return b;
  endfunction

endpackage

### design/kfp_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfp_seq
// Message sequencer: walks the held request through header, payload and
// checksum bytes, one byte per cycle unless the output stalls, and keeps the message state.
// ----------------------------------------------------------------------------
module kfp_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           hold_valid,
  input  kfp_pkg::byte_t pb,
  input  kfp_pkg::byte_t len,
  input  kfp_pkg::mode_t mode,
  input  kfp_pkg::byte_t tar,
  input  kfp_pkg::byte_t src,
  input  logic           out_ready,
  output kfp_pkg::emit_t emit,
  output logic           done
);
  import kfp_pkg::*;

  seq_state_t st_r, st_nxt;
  seq_state_t ph;
  logic       in_msg_r, in_msg_nxt;
  byte_t      left_r, left_nxt;
  byte_t      sum_r, sum_nxt;
  logic [1:0] hidx_r, hidx_nxt;
  logic       drop;
  logic       last_hdr;
  byte_t      left_dec;
  logic       fire;

  // Effective phase: a fresh request starts in header or payload
  always_comb begin
    ph   = st_r;
    drop = 1'b0;
    if (st_r == ST_START) begin
      if (in_msg_r) begin
        ph = ST_PAY;
      end else begin
        ph   = ST_HDR;
        drop = (len == 8'd0);
      end
    end
  end

  assign last_hdr = ({1'b0, hidx_r} + 3'd1) == hdr_count(mode);
  assign left_dec = (in_msg_r ? left_r : len) - 8'd1;
  assign fire     = hold_valid && !drop && out_ready;

  // Next state
  always_comb begin
    st_nxt = st_r;
    if (hold_valid) begin
      if (drop) begin
        st_nxt = ST_START;
      end else if (fire) begin
        case (ph)
          ST_HDR:  st_nxt = last_hdr ? ST_PAY : ST_HDR;
          ST_PAY:  st_nxt = (left_dec == 8'd0) ? ST_SUM : ST_START;
          ST_SUM:  st_nxt = ST_START;
          default: st_nxt = ST_START;
        endcase
      end
    end
  end

  // Outputs and message state
  always_comb begin
    emit       = '0;
    done       = 1'b0;
    in_msg_nxt = in_msg_r;
    left_nxt   = left_r;
    sum_nxt    = sum_r;
    hidx_nxt   = hidx_r;
    emit.valid = hold_valid && !drop;
    case (ph)
      ST_HDR: begin
        emit.data = hdr_byte(mode, hidx_r, len, tar, src);
        emit.kind = KIND_HEADER;
      end
      ST_PAY: begin
        emit.data = pb;
        emit.kind = KIND_PAYLOAD;
      end
      default: begin
        emit.data = sum_r;
        emit.kind = KIND_CHECKSUM;
        emit.eof  = 1'b1;
      end
    endcase
    if (hold_valid && drop) begin
      done = 1'b1;
    end else if (fire) begin
      case (ph)
        ST_HDR: begin
          sum_nxt  = sum_r + emit.data;
          hidx_nxt = last_hdr ? 2'd0 : hidx_r + 2'd1;
        end
        ST_PAY: begin
          sum_nxt    = sum_r + emit.data;
          left_nxt   = left_dec;
          in_msg_nxt = 1'b1;
          done       = (left_dec != 8'd0);
        end
        default: begin
          sum_nxt    = 8'd0;
          in_msg_nxt = 1'b0;
          done       = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_START;
      in_msg_r <= 1'b0;
      left_r   <= 8'd0;
      sum_r    <= 8'd0;
      hidx_r   <= 2'd0;
    end else begin
      st_r     <= st_nxt;
      in_msg_r <= in_msg_nxt;
      left_r   <= left_nxt;
      sum_r    <= sum_nxt;
      hidx_r   <= hidx_nxt;
    end
  end

  // Checksum only ever follows the last payload byte
  a_sum_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_SUM |-> in_msg_r && left_r == 8'd0)
    else $error("checksum state without finished payload");

  // Header index is only live while sending the header
  a_hidx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != ST_HDR |-> hidx_r == 2'd0)
    else $error("header index left nonzero");

  // Mid-request states need the request still held
  a_hold_mid: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != ST_START |-> hold_valid)
    else $error("sequencer busy without a held request");

endmodule

### design/kfp_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfp_out_reg
// Result register: holds one framed byte until the receiver takes it.
// ----------------------------------------------------------------------------
module kfp_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  kfp_pkg::emit_t emit,
  output logic           load,
  input  logic           out_stall,
  output logic           out_valid,
  output logic [7:0]     out_byte,
  output logic [1:0]     out_byte_kind,
  output logic           out_end_of_frame
);
  import kfp_pkg::*;

  logic  valid_r;
  byte_t data_r;
  kind_t kind_r;
  logic  eof_r;

  // Register is free when empty or being drained this cycle
  assign load = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && emit.valid) begin
      data_r <= emit.data;
      kind_r <= emit.kind;
      eof_r  <= emit.eof;
    end
  end

  assign out_valid        = valid_r;
  assign out_byte         = data_r;
  assign out_byte_kind    = kind_r;
  assign out_end_of_frame = eof_r;

endmodule

### design/kwp_frame_packer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwp_frame_packer_top
// KWP2000 message framer: header per mode, payload pass-through, sum byte.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | in_valid / in_stall  | in_payload_byte, in_frame_length
//  result   | out_valid / out_stall| out_byte, out_byte_kind, out_end_of_frame
//  config   | cfg_we               | cfg_index, cfg_wdata
//
//  Unstalled, the sequencer sends one result byte per cycle to the output register.
//  A mid-message payload byte yields only itself; a first byte is preceded by
//  the header bytes of the mode, and a last byte is followed by the checksum.
//  Reset (rst_n low, synchronous) clears config, valid flags and message state.
//  A held output stalls the sequencer, which stalls the input register.
// ----------------------------------------------------------------------------
module kwp_frame_packer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_payload_byte,
  input  logic [7:0] in_frame_length,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] out_byte_kind,
  output logic       out_end_of_frame,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);
  import kfp_pkg::*;

  mode_t  mode_r;
  byte_t  tar_r;
  byte_t  src_r;
  logic   hold_v_r;
  byte_t  pb_r;
  byte_t  len_r;
  emit_t  emit;
  logic   done;
  logic   load;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_8X;
      tar_r  <= 8'd0;
      src_r  <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_MODE: mode_r <= cfg_wdata[2:0];
        CFG_TARGET:     tar_r  <= cfg_wdata;
        CFG_SOURCE:     src_r  <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  // Input register: takes a new request when empty or when the held one finishes
  assign in_stall = hold_v_r && !done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (!in_stall) begin
      hold_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      pb_r  <= in_payload_byte;
      len_r <= in_frame_length;
    end
  end

  kfp_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .hold_valid (hold_v_r),
    .pb         (pb_r),
    .len        (len_r),
    .mode       (mode_r),
    .tar        (tar_r),
    .src        (src_r),
    .out_ready  (load),
    .emit       (emit),
    .done       (done)
  );

  kfp_out_reg u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .emit             (emit),
    .load             (load),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_byte         (out_byte),
    .out_byte_kind    (out_byte_kind),
    .out_end_of_frame (out_end_of_frame)
  );

endmodule
